>>> src/kct_pkg.sv
// shared types, constants, keyword table and helper functions for the keyword color tagger
package kct_pkg;

	localparam int MAX_WORD = 12;
	localparam int IDX_W = $clog2(MAX_WORD);
	localparam int WLEN_W = $clog2(MAX_WORD + 1);
	localparam int COLOR_W = 4;
	localparam int KW_COUNT = 64;
	localparam int KW_CHARS = 12;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [WLEN_W-1:0] wlen_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [MAX_WORD-1:0][7:0] word_t;
	typedef logic [8*KW_CHARS-1:0] kw_text_t;
	typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;
	typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

	localparam wlen_t WORD_FULL = wlen_t'(MAX_WORD);
	localparam color_t DEFAULT_COLOR_RST = 4'h7;
	localparam fifo_cnt_t FIFO_FULL_CNT = fifo_cnt_t'(FIFO_DEPTH);
	localparam fifo_ptr_t FIFO_LAST_PTR = fifo_ptr_t'(FIFO_DEPTH - 1);

	// one flushed word and/or one pass-through byte, handed from front to back
	typedef struct packed {
		word_t  word;
		wlen_t  wlen;
		color_t wcolor;
		logic   has_ch;
		logic [7:0] ch;
		color_t dcolor;
	} cmd_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		"break", "continue", "return",
		"const", "volatile", "extern", "static",
		"char", "int", "short", "float",
		"double", "long", "bool", "void",
		"double\137t", "float_t", "fpos_t",
		"max_align\137t", "mbstate\137t", "nullptr\137t",
		"ptrdiff\137t", "sig_atomic\137t", "size_t",
		"time_t", "wchar_t", "wint_t", "FILE",
		"uint8_t", "uint16\137t", "uint32\137t", "uint64\137t",
		"int8_t", "int16_t", "int32_t", "int64_t",
		"struct", "enum", "union", "typedef",
		"unsigned", "signed", "sizeof", "register",
		"do", "if", "while", "switch",
		"for", "case", "default", "goto",
		"include", "pragma", "define", "ifdef",
		"ifndef", "endif", "undef", "error",
		"main",
		"0x", "0o", "0b"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd8, 4'd6,
		4'd5, 4'd8, 4'd6, 4'd6,
		4'd4, 4'd3, 4'd5, 4'd5,
		4'd6, 4'd4, 4'd4, 4'd4,
		4'd8, 4'd7, 4'd6,
		4'd11, 4'd9, 4'd9,
		4'd9, 4'd12, 4'd6,
		4'd6, 4'd7, 4'd6, 4'd4,
		4'd7, 4'd8, 4'd8, 4'd8,
		4'd6, 4'd7, 4'd7, 4'd7,
		4'd6, 4'd4, 4'd5, 4'd7,
		4'd8, 4'd6, 4'd6, 4'd8,
		4'd2, 4'd2, 4'd5, 4'd6,
		4'd3, 4'd4, 4'd7, 4'd4,
		4'd7, 4'd6, 4'd6, 4'd5,
		4'd6, 4'd5, 4'd5, 4'd5,
		4'd4,
		4'd2, 4'd2, 4'd2
	};

	localparam color_t KW_COLOR [KW_COUNT] = '{
		4'h5, 4'h5, 4'h5,
		4'h9, 4'h9, 4'h9, 4'h9,
		4'h9, 4'h9, 4'h9, 4'h9,
		4'h9, 4'h9, 4'h9, 4'h9,
		4'ha, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha, 4'ha,
		4'ha, 4'ha, 4'ha, 4'ha,
		4'he, 4'he, 4'he, 4'he,
		4'h9, 4'h9, 4'h9, 4'h9,
		4'he, 4'he, 4'he, 4'he,
		4'he, 4'he, 4'he, 4'he,
		4'hb, 4'hb, 4'hb, 4'hb,
		4'hb, 4'hb, 4'hb, 4'hb,
		4'h6,
		4'ha, 4'ha, 4'ha
	};

	function automatic logic is_sep(input logic [7:0] b);
		return b inside {8'h00, 8'h20, [8'h09:8'h0d], 8'h23, 8'h2c, 8'h2e, 8'h28, 8'h29,
			8'h2b, 8'h2d, 8'h2f, 8'h2a, 8'h3d, 8'h7e, 8'h5b, 8'h5d, 8'h3b};
	endfunction

	// character k of keyword e, zero past its end
	function automatic logic [7:0] kw_byte(input int e, input wlen_t k);
		kw_text_t t;
		int sh;
		if (int'(k) >= int'(KW_LEN[e])) begin
			return 8'h00;
		end
		sh = 8 * (int'(KW_LEN[e]) - 1 - int'(k));
		t = KW_TEXT[e] >> sh;
		return t[7:0];
	endfunction

endpackage

>>> src/keyword_color_tagger_top.sv
// Keyword color tagger: takes one source byte per cycle while full is low and returns
// the bytes tagged with a color, a word in its keyword color once its separator or end of
// stream arrives. A buffered word byte produces nothing until the word ends. A separator
// releases the buffered word (n bytes) plus the separator itself, end of stream releases
// only the n buffered bytes, a byte past the twelve-byte word buffer releases all twelve
// buffered bytes plus itself, and each later byte of that word releases only itself; the
// beats leave one per cycle on the single result port while pop is held. The first beat
// an input releases passes through the command queue and then the result register before
// it is on the result ports. Full rises while both entries of the two-entry command queue
// between front and back hold commands not yet fully emitted, and it then holds off every
// input byte, word bytes included. The default color register is written through
// cfg_we/cfg_wdata and resets to 7; there is no clearing pass after reset.
module keyword_color_tagger_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      char_in,
	input  logic            end_of_stream,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      char_out,
	output logic [3:0]      color,
	output logic            last,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_wdata
);

	kct_pkg::cmd_t cmd_in;
	kct_pkg::cmd_t cmd_head;
	logic cmd_push;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;

	kct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_in       (char_in),
		.end_of_stream (end_of_stream),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd_in),
		.cmd_push      (cmd_push),
		.cmd_full      (cmd_full)
	);

	kct_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	kct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.head_valid (!cmd_empty),
		.head_pop   (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.char_out   (char_out),
		.color      (color),
		.last       (last)
	);

endmodule

>>> src/kct_cmd_fifo.sv
// short command queue between the classifying front and the emitting back
module kct_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  kct_pkg::cmd_t   wr_data,
	output logic            full,
	input  logic            rd_en,
	output kct_pkg::cmd_t   rd_data,
	output logic            empty
);

	kct_pkg::cmd_t mem_q [kct_pkg::FIFO_DEPTH];
	kct_pkg::fifo_ptr_t wr_ptr_q;
	kct_pkg::fifo_ptr_t rd_ptr_q;
	kct_pkg::fifo_cnt_t count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == kct_pkg::FIFO_FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == kct_pkg::FIFO_LAST_PTR) ? '0
					: kct_pkg::fifo_ptr_t'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == kct_pkg::FIFO_LAST_PTR) ? '0
					: kct_pkg::fifo_ptr_t'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= kct_pkg::fifo_cnt_t'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= kct_pkg::fifo_cnt_t'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("command queue written while full");

endmodule

>>> src/kct_front.sv
// input side: separator detection, word buffering, incremental keyword match
module kct_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      char_in,
	input  logic            end_of_stream,
	input  logic            cfg_we,
	input  kct_pkg::color_t cfg_wdata,
	output kct_pkg::cmd_t   cmd,
	output logic            cmd_push,
	input  logic            cmd_full
);

	kct_pkg::word_t word_q;
	kct_pkg::wlen_t wlen_q;
	logic passing_q;
	logic [kct_pkg::KW_COUNT-1:0] cand_q;
	kct_pkg::color_t default_color_q;

	logic accept;
	logic sep;
	logic store;
	logic overflow;
	logic [kct_pkg::KW_COUNT-1:0] hit;
	logic [kct_pkg::KW_COUNT-1:0] match;
	kct_pkg::color_t kw_color;
	kct_pkg::color_t word_color;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign sep = end_of_stream || kct_pkg::is_sep(char_in);
	assign overflow = !sep && !passing_q && (wlen_q == kct_pkg::WORD_FULL);
	assign store = accept && !sep && !passing_q && (wlen_q != kct_pkg::WORD_FULL);

	always_comb begin
		kw_color = '0;
		for (int e = 0; e < kct_pkg::KW_COUNT; e++) begin
			hit[e] = (kct_pkg::kw_byte(e, wlen_q) == char_in);
			match[e] = cand_q[e] && (kct_pkg::wlen_t'(kct_pkg::KW_LEN[e]) == wlen_q);
			kw_color = kw_color | (match[e] ? kct_pkg::KW_COLOR[e] : '0);
		end
		word_color = (|match) ? kw_color : default_color_q;
	end

	always_comb begin
		cmd.word = word_q;
		cmd.wlen = '0;
		cmd.wcolor = word_color;
		cmd.has_ch = 1'b1;
		cmd.ch = char_in;
		cmd.dcolor = default_color_q;
		cmd_push = 1'b0;
		if (accept) begin
			if (sep) begin
				cmd.wlen = wlen_q;
				cmd.has_ch = !end_of_stream;
				cmd_push = (wlen_q != '0) || !end_of_stream;
			end else if (passing_q) begin
				cmd_push = 1'b1;
			end else if (overflow) begin
				cmd.wlen = wlen_q;
				cmd.wcolor = default_color_q;
				cmd_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			passing_q <= 1'b0;
			cand_q <= '1;
			default_color_q <= kct_pkg::DEFAULT_COLOR_RST;
		end else begin
			if (cfg_we) begin
				default_color_q <= cfg_wdata;
			end
			if (accept) begin
				if (sep) begin
					wlen_q <= '0;
					passing_q <= 1'b0;
					cand_q <= '1;
				end else if (overflow) begin
					wlen_q <= '0;
					passing_q <= 1'b1;
					cand_q <= '1;
				end else if (store) begin
					wlen_q <= kct_pkg::wlen_t'(wlen_q + 1'b1);
					cand_q <= cand_q & hit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			word_q[wlen_q[kct_pkg::IDX_W-1:0]] <= char_in;
		end
	end

	a_wlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= kct_pkg::WORD_FULL)
		else $error("word length past buffer size");

	a_pass_empty_buf: assert property (@(posedge clk) disable iff (!arst_n)
		passing_q |-> (wlen_q == '0))
		else $error("long word pass-through with buffered bytes");

endmodule

>>> src/kct_back.sv
// output side: head command bytes to result register, one per cycle while popped
module kct_back (
	input  logic            clk,
	input  logic            arst_n,
	input  kct_pkg::cmd_t   head,
	input  logic            head_valid,
	output logic            head_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      char_out,
	output kct_pkg::color_t color,
	output logic            last
);

	kct_pkg::wlen_t idx_q;
	logic ovalid_q;
	logic [7:0] char_q;
	kct_pkg::color_t color_q;
	logic last_q;

	logic load;
	logic in_word;
	logic [7:0] res_ch;
	kct_pkg::color_t res_color;
	logic res_last;

	assign load = head_valid && (!ovalid_q || pop);
	assign in_word = idx_q < head.wlen;
	assign res_ch = in_word ? head.word[idx_q[kct_pkg::IDX_W-1:0]] : head.ch;
	assign res_color = in_word ? head.wcolor : head.dcolor;
	assign res_last = in_word
		? ((kct_pkg::wlen_t'(idx_q + 1'b1) == head.wlen) && !head.has_ch) : 1'b1;
	assign head_pop = load && res_last;

	assign empty = !ovalid_q;
	assign char_out = char_q;
	assign color = color_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				idx_q <= res_last ? '0 : kct_pkg::wlen_t'(idx_q + 1'b1);
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= res_ch;
			color_q <= res_color;
			last_q <= res_last;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head.wlen))
		else $error("emit index past word length");

	a_word_only_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !head.has_ch) |-> (idx_q < head.wlen))
		else $error("word-only command ran past its last byte");

	a_partial_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> head_valid)
		else $error("partly emitted command left the queue");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the keyword color tagger: source text in, colored beats checked
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [7:0] ch;
		logic [3:0] col;
		logic       lst;
	} out_beat_t;

	typedef enum {TK_KEYWORD, TK_IDENT, TK_NEAR_MISS, TK_LONG, TK_NOISE} token_kind_t;

	localparam int WORD_MAX = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_CAP = 40;

	localparam logic [3:0] COL_FLOW = 4'h5;
	localparam logic [3:0] COL_TYPE = 4'h9;
	localparam logic [3:0] COL_LIB = 4'ha;
	localparam logic [3:0] COL_BLOCK = 4'he;
	localparam logic [3:0] COL_PREPROC = 4'hb;
	localparam logic [3:0] COL_MAIN = 4'h6;
	localparam logic [3:0] COL_RESET = 4'h7;
	localparam logic [3:0] COL_MIN = 4'h0;
	localparam logic [3:0] COL_MAX = 4'hf;

	string kw_names [64] = '{
		"break", "continue", "return",
		"const", "volatile", "extern", "static", "char", "int", "short", "float",
		"double", "long", "bool", "void",
		"double\137t", "float_t", "fpos_t", "max_align\137t", "mbstate\137t", "nullptr\137t",
		"ptrdiff\137t", "sig_atomic\137t", "size_t", "time_t", "wchar_t", "wint_t", "FILE",
		"uint8_t", "uint16\137t", "uint32\137t", "uint64\137t",
		"int8_t", "int16_t", "int32_t", "int64_t",
		"struct", "enum", "union", "typedef",
		"unsigned", "signed", "sizeof", "register",
		"do", "if", "while", "switch", "for", "case", "default", "goto",
		"include", "pragma", "define", "ifdef", "ifndef", "endif", "undef", "error",
		"main",
		"0x", "0o", "0b"
	};

	logic [3:0] kw_colors [64] = '{
		COL_FLOW, COL_FLOW, COL_FLOW,
		COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE,
		COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE,
		COL_LIB, COL_LIB, COL_LIB, COL_LIB, COL_LIB, COL_LIB,
		COL_LIB, COL_LIB, COL_LIB, COL_LIB, COL_LIB, COL_LIB, COL_LIB,
		COL_LIB, COL_LIB, COL_LIB, COL_LIB,
		COL_LIB, COL_LIB, COL_LIB, COL_LIB,
		COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK,
		COL_TYPE, COL_TYPE, COL_TYPE, COL_TYPE,
		COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK, COL_BLOCK,
		COL_PREPROC, COL_PREPROC, COL_PREPROC, COL_PREPROC,
		COL_PREPROC, COL_PREPROC, COL_PREPROC, COL_PREPROC,
		COL_MAIN,
		COL_LIB, COL_LIB, COL_LIB
	};

	string punct_chars = "#,.()+-/*=~[];";
	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] char_out;
	logic [3:0] color;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'h0;

	// predictor state
	logic [7:0] word_buf [WORD_MAX];
	int         word_len = 0;
	bit         long_pass = 1'b0;
	logic [3:0] plain_color = COL_RESET;
	out_beat_t  due_beats [$];

	int    send_idle_pct = 11;
	int    pop_stall_pct = 11;
	int    cycle_count = 0;
	int    items_sent = 0;
	int    beats_checked = 0;
	int    mismatch_count = 0;
	int    keyword_hits = 0;
	int    overflow_count = 0;
	string colors_used = "7";

	keyword_color_tagger_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.char_in       (char_in),
		.end_of_stream (end_of_stream),
		.empty         (empty),
		.pop           (pop),
		.char_out      (char_out),
		.color         (color),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_word_break(input logic [7:0] b);
		case (b)
			8'h00, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20,
			"#", ",", ".", "(", ")", "+", "-", "/", "*", "=", "~", "[", "]", ";": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// works out the colored beats that one accepted byte releases
	function automatic void tag_source_byte(input logic [7:0] b, input logic eos);
		logic [11:0] outs [$];
		logic [3:0]  wcol;
		bit          hit;
		out_beat_t   beat;
		hit = 1'b0;
		if (eos || is_word_break(b)) begin
			if (word_len > 0) begin
				wcol = plain_color;
				for (int i = 0; i < 64; i++) begin
					if (!hit && kw_names[i].len() == word_len) begin
						hit = 1'b1;
						for (int k = 0; k < word_len; k++)
							if (kw_names[i][k] != word_buf[k])
								hit = 1'b0;
						if (hit)
							wcol = kw_colors[i];
					end
				end
				if (hit)
					keyword_hits++;
				for (int k = 0; k < word_len; k++)
					outs.push_back({wcol, word_buf[k]});
				word_len = 0;
			end
			long_pass = 1'b0;
			if (!eos)
				outs.push_back({plain_color, b});
		end else if (long_pass) begin
			outs.push_back({plain_color, b});
		end else if (word_len < WORD_MAX) begin
			word_buf[word_len] = b;
			word_len++;
		end else begin
			for (int k = 0; k < word_len; k++)
				outs.push_back({plain_color, word_buf[k]});
			word_len = 0;
			outs.push_back({plain_color, b});
			long_pass = 1'b1;
			overflow_count++;
		end
		foreach (outs[i]) begin
			beat.ch = outs[i][7:0];
			beat.col = outs[i][11:8];
			beat.lst = (i == outs.size() - 1);
			due_beats.push_back(beat);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		pop <= ($urandom_range(0, 99) >= pop_stall_pct);
	end

	// result side: every popped beat against the oldest predicted one
	always @(posedge clk) begin
		out_beat_t exp_beat;
		if (arst_n && pop && !empty) begin
			if (due_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat char %h color %h last %b",
					char_out, color, last));
			end else begin
				exp_beat = due_beats.pop_front();
				if (char_out !== exp_beat.ch)
					report_mismatch($sformatf("beat %0d char_out %h, want %h",
						beats_checked, char_out, exp_beat.ch));
				if (color !== exp_beat.col)
					report_mismatch($sformatf("beat %0d (char %h) color %h, want %h",
						beats_checked, exp_beat.ch, color, exp_beat.col));
				if (last !== exp_beat.lst)
					report_mismatch($sformatf("beat %0d (char %h) last %b, want %b",
						beats_checked, exp_beat.ch, last, exp_beat.lst));
			end
			beats_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycle_count,
				due_beats.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic eos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		char_in <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tag_source_byte(b, eos);
		items_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_color(input logic [3:0] c);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		plain_color = c;
		colors_used = {colors_used, $sformatf(" %0d", c)};
	endtask

	function automatic logic [7:0] pick_word_byte();
		logic [7:0] b;
		if ($urandom_range(0, 99) < 75)
			return ident_chars[$urandom_range(0, ident_chars.len() - 1)];
		do
			b = 8'($urandom_range(0, 255));
		while (is_word_break(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_separator();
		int r;
		r = $urandom_range(0, 20);
		if (r < 14)
			return punct_chars[r];
		if (r == 14)
			return 8'h20;
		if (r == 15)
			return 8'h00;
		return 8'h09 + 8'(r - 16);
	endfunction

	// a word of the given kind, a separator or end of stream, maybe one more of each
	task automatic send_token(input token_kind_t kind);
		logic [7:0] tok [$];
		string      kw;
		int         pos;
		case (kind)
			TK_KEYWORD, TK_NEAR_MISS: begin
				kw = kw_names[$urandom_range(0, 63)];
				for (int i = 0; i < kw.len(); i++)
					tok.push_back(kw[i]);
				if (kind == TK_NEAR_MISS) begin
					case ($urandom_range(0, 2))
						0: void'(tok.pop_back());
						1: tok.push_back(pick_word_byte());
						default: begin
							pos = $urandom_range(0, tok.size() - 1);
							tok[pos] = tok[pos] ^ 8'h20;
						end
					endcase
				end
			end
			TK_IDENT:
				repeat ($urandom_range(1, WORD_MAX)) tok.push_back(pick_word_byte());
			TK_LONG:
				repeat ($urandom_range(WORD_MAX + 1, 2 * WORD_MAX)) tok.push_back(pick_word_byte());
			default:
				repeat ($urandom_range(1, 4)) tok.push_back(8'($urandom_range(0, 255)));
		endcase
		foreach (tok[i])
			send_beat(tok[i], 1'b0);
		if ($urandom_range(0, 99) < 10)
			send_beat(8'($urandom_range(0, 255)), 1'b1);
		else
			send_beat(pick_separator(), 1'b0);
		if ($urandom_range(0, 99) < 15)
			send_beat(pick_separator(), 1'b0);
		if ($urandom_range(0, 99) < 5)
			send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic run_text(input int n_items, input int long_pct);
		int start;
		int r;
		start = items_sent;
		while (items_sent - start < n_items) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < long_pct)
				send_token(TK_LONG);
			else if (r < 45)
				send_token(TK_KEYWORD);
			else if (r < 70)
				send_token(TK_IDENT);
			else if (r < 85)
				send_token(TK_NEAR_MISS);
			else
				send_token(TK_NOISE);
		end
	endtask

	// lone separators, high bytes, end of stream with and without a word, full-length keyword
	task automatic test_directed();
		send_beat(8'h20, 1'b0);
		send_beat(8'h00, 1'b0);
		send_string("if(");
		send_beat(8'hff, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hff, 1'b1);
		send_beat(8'h00, 1'b1);
		send_string("sig_atomic\137t");
		send_beat(8'h0d, 1'b0);
	endtask

	task automatic test_keyword_text();
		write_default_color(COL_MIN);
		run_text(120, 3);
	endtask

	task automatic test_long_words();
		write_default_color(COL_MAX);
		run_text(70, 60);
	endtask

	task automatic test_color_sweep();
		repeat (3) begin
			write_default_color(4'($urandom_range(0, 15)));
			run_text(25, 8);
		end
	endtask

	task automatic test_back_to_back();
		write_default_color(4'($urandom_range(0, 15)));
		send_idle_pct = 0;
		pop_stall_pct = 0;
		run_text(70, 8);
		wait_drained();
		send_idle_pct = 11;
		pop_stall_pct = 11;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_keyword_text();
		test_long_words();
		test_color_sweep();
		test_back_to_back();
		wait_drained();
		$display("%0d source bytes sent, %0d colored beats checked", items_sent, beats_checked);
		$display("%0d keyword words, %0d buffer overflows, default colors: %s",
			keyword_hits, overflow_count, colors_used);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
